### hw/rtl/i2ar_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2ar_pkg;

    // Value and digit geometry
    localparam int VALUE_WIDTH = 64;
    localparam int MAX_DIGITS  = 64;
    localparam int DIGIT_W     = 4;
    localparam int ADDR_W      = $clog2(MAX_DIGITS);
    localparam int COUNT_W     = $clog2(MAX_DIGITS + 1);
    localparam int CHAR_W      = 7;

    // Divider: quotient bits retired per cycle
    localparam int STEP_BITS   = 8;
    localparam int DIV_CYCLES  = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_W       = DIV_CYCLES * STEP_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_CYCLES + 1);

    // Configuration registers
    localparam int RADIX_W     = 5;
    localparam int CFG_IDX_W   = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED = 2'd1;
    localparam logic [RADIX_W-1:0]   RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0]   RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0]   RADIX_MAX   = 5'd16;

    // ASCII offsets: '0' for digits, '7' so that 10 maps to 'A'
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'd55;
    localparam logic [DIGIT_W-1:0] DEC_LIMIT = 4'd10;

    typedef struct packed {
        logic                   done;
        logic [VALUE_WIDTH-1:0] quotient;
        logic [DIGIT_W-1:0]     remainder;
    } div_result_t;

    function automatic logic [RADIX_W-1:0] effective_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        if (r < RADIX_MIN)
            res = RADIX_MIN;
        else if (r > RADIX_MAX)
            res = RADIX_MAX;
        else
            res = r;
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {{(CHAR_W - DIGIT_W){1'b0}}, d};
        return (d < DEC_LIMIT) ? (dx + CHAR_ZERO) : (dx + CHAR_ALPHA);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/integer_to_ascii_radix_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Integer to ASCII converter. Each number transfer is turned into its digits
// in the base held in the radix register (2..16; 0 and 1 act as 2, 17..31 as
// 16), sent one character per out transfer, most significant first, with
// 'A'..'F' for digit values 10..15 and is_last on the final digit. Zero gives
// a single '0'. With signed_mode set the number is read as two's complement
// and only the digits of its magnitude are sent (no minus sign). One number
// is in flight at a time: in_stall stays high from the accepting edge until
// the last character has transferred. Each digit of the value goes through
// the shared divider (launch, the division steps, then storing the remainder
// in the digit store), then each character goes through a digit-store read,
// the output load and the transfer, which out_stall can hold; a 64-bit value
// in base 2, with the most digits, is the worst case. Configuration writes are
// always ready but must only be issued while the block is idle.
module integer_to_ascii_radix_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [i2ar_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [i2ar_pkg::RADIX_W-1:0]     cfg_data,
    // number input
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [i2ar_pkg::VALUE_WIDTH-1:0] number,
    // character output
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [i2ar_pkg::CHAR_W-1:0]      ascii_char,
    output logic                                 is_last
);
    import i2ar_pkg::*;

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for a number
    localparam logic [2:0] ST_START = 3'd1;  // launch divider on quotient_reg
    localparam logic [2:0] ST_DIV   = 3'd2;  // divider busy
    localparam logic [2:0] ST_READ  = 3'd3;  // digit-store read issued
    localparam logic [2:0] ST_LOAD  = 3'd4;  // read data into output register
    localparam logic [2:0] ST_OUT   = 3'd5;  // character waiting for transfer

    logic [2:0]             state_reg, state_next;
    logic [RADIX_W-1:0]     radix_reg, radix_next;
    logic                   signed_reg, signed_next;
    logic [VALUE_WIDTH-1:0] quotient_reg, quotient_next;
    logic [COUNT_W-1:0]     digit_count_reg, digit_count_next;
    logic [ADDR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]      char_reg, char_next;
    logic                   last_reg, last_next;

    logic                   in_fire;
    logic                   cfg_fire;
    logic [VALUE_WIDTH-1:0] magnitude;
    logic                   div_start;
    div_result_t            div_res;
    logic                   ram_we;
    logic [DIGIT_W-1:0]     ram_rdata;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;

    // two's complement magnitude; the most negative value maps onto itself,
    // which read unsigned is exactly its magnitude
    always_comb
    begin
        if (signed_reg && number[VALUE_WIDTH-1])
            magnitude = ~number + 1'b1;
        else
            magnitude = number;
    end

    assign div_start = (state_reg == ST_START);
    assign ram_we    = (state_reg == ST_DIV) && div_res.done;

    i2ar_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (quotient_reg),
        .divisor  (effective_radix(radix_reg)),
        .result   (div_res)
    );

    // digits land least significant first at address 0 upward,
    // and are read back from the top down
    i2ar_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_digits (
        .clk   (clk),
        .we    (ram_we),
        .waddr (digit_count_reg[ADDR_W-1:0]),
        .wdata (div_res.remainder),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next       = state_reg;
        radix_next       = radix_reg;
        signed_next      = signed_reg;
        quotient_next    = quotient_reg;
        digit_count_next = digit_count_reg;
        rd_ptr_next      = rd_ptr_reg;
        out_valid_next   = out_valid_reg;
        char_next        = char_reg;
        last_next        = last_reg;

        if (cfg_fire)
        begin
            if (cfg_index == CFG_RADIX)
                radix_next = cfg_data;
            else if (cfg_index == CFG_SIGNED)
                signed_next = cfg_data[0];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    quotient_next    = magnitude;
                    digit_count_next = '0;
                    state_next       = ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_res.done)
                begin
                    quotient_next    = div_res.quotient;
                    digit_count_next = digit_count_reg + 1'b1;
                    // stop at a zero quotient or a full digit store
                    if ((div_res.quotient == '0) ||
                        (digit_count_reg == COUNT_W'(MAX_DIGITS - 1)))
                    begin
                        rd_ptr_next = digit_count_reg[ADDR_W-1:0];
                        state_next  = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_START;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                char_next      = digit_char(ram_rdata);
                last_next      = (rd_ptr_reg == '0);
                out_valid_next = 1'b1;
                state_next     = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    if (last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg - 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            radix_reg       <= RADIX_RESET;
            signed_reg      <= 1'b0;
            quotient_reg    <= '0;
            digit_count_reg <= '0;
            rd_ptr_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            radix_reg       <= radix_next;
            signed_reg      <= signed_next;
            quotient_reg    <= quotient_next;
            digit_count_reg <= digit_count_next;
            rd_ptr_reg      <= rd_ptr_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign ascii_char = char_reg;
    assign is_last    = last_reg;

endmodule

`default_nettype wire

### hw/rtl/i2ar_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module i2ar_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/i2ar_divider.sv
`timescale 1ns / 1ps
`default_nettype none

// Long division of a value by a small radix, STEP_BITS quotient bits a cycle.
// done pulses one cycle; quotient and remainder hold until the next start.
module i2ar_divider (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [i2ar_pkg::VALUE_WIDTH-1:0] dividend,
    input  wire logic [i2ar_pkg::RADIX_W-1:0]     divisor,
    output i2ar_pkg::div_result_t                 result
);
    import i2ar_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PAD_W-1:0]      work_reg, work_next;
    logic [DIGIT_W-1:0]    rem_reg, rem_next;

    logic [PAD_W-1:0]      step_work;
    logic [DIGIT_W-1:0]    step_rem;

    // Shift-subtract over STEP_BITS bits; partial remainder stays below divisor
    always_comb
    begin
        logic [DIGIT_W:0] trial;
        logic [DIGIT_W:0] diff;
        step_work = work_reg;
        step_rem  = rem_reg;
        for (int i = 0; i < STEP_BITS; i++)
        begin
            trial     = {step_rem, step_work[PAD_W-1]};
            diff      = trial - divisor;
            step_work = {step_work[PAD_W-2:0], 1'b0};
            if (trial >= divisor)
            begin
                step_rem     = diff[DIGIT_W-1:0];
                step_work[0] = 1'b1;
            end
            else
            begin
                step_rem = trial[DIGIT_W-1:0];
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            work_next = PAD_W'(dividend);
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            work_next = step_work;
            rem_next  = step_rem;
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

    assign result.done      = done_reg;
    assign result.quotient  = work_reg[VALUE_WIDTH-1:0];
    assign result.remainder = rem_reg;

endmodule

`default_nettype wire

### hw/rtl/i2ar_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module i2ar_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_stall,
    input wire logic                            out_valid,
    input wire logic                            out_stall,
    input wire logic [i2ar_pkg::CHAR_W-1:0]      ascii_char,
    input wire logic                            is_last
);
    import i2ar_pkg::*;

    // a number in flight blocks the input
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after a number transfer");

    // characters only appear while a number is in flight
    a_out_implies_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("character shown while input is open");

    // only digit characters are produced
    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((ascii_char >= 7'd48 && ascii_char <= 7'd57) ||
                       (ascii_char >= 7'd65 && ascii_char <= 7'd70)))
        else $error("character outside 0-9, A-F");

    // a stalled character holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(ascii_char) && $stable(is_last)))
        else $error("stalled character changed");

    // nothing follows the last character until a new number
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && is_last) |=> (!out_valid && !in_stall))
        else $error("activity after the last character");

endmodule

bind integer_to_ascii_radix_top i2ar_checker u_i2ar_checker (.*);

`default_nettype wire

### tb/tb_integer_to_ascii_radix_top.sv
`timescale 1ns / 1ps

// Checks the integer-to-ASCII converter. Every accepted number is turned into
// expected characters by a local predictor (or by a typed string for the
// simple directed rows). The monitor then compares each out transfer against
// the oldest expected character.
module tb_integer_to_ascii_radix_top;
    import i2ar_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 10;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 56;
    // Quiet cycles after the last character before calling the block idle.
    localparam int DRAIN_CYCLES = 40;
    // Worst case is about 470 numbers of up to 64 digits each, with every
    // character held by a full stall burst. The limit below is several times
    // that.
    localparam int CYCLE_LIMIT  = 4_000_000;

    // Register indexes past the last real register. Writes to these must be
    // dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam logic [CHAR_W-1:0]      ASCII_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0]      ASCII_UPPER_A = 7'h41;
    localparam logic [VALUE_WIDTH-1:0] ALL_ONES      = '1;
    localparam logic [VALUE_WIDTH-1:0] MOST_NEG      = {1'b1, {(VALUE_WIDTH - 1){1'b0}}};
    localparam logic [VALUE_WIDTH-1:0] MINUS_123     = ~64'd123 + 64'd1;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } char_exp_t;

    typedef enum logic {ROW_NUMBER, ROW_WRITE} row_kind_e;

    typedef struct packed {
        row_kind_e              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [RADIX_W-1:0]     data;
        logic [VALUE_WIDTH-1:0] value;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [RADIX_W-1:0]     cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [VALUE_WIDTH-1:0] number;
    logic                   out_valid;
    logic                   out_stall;
    logic [CHAR_W-1:0]      ascii_char;
    logic                   is_last;

    integer_to_ascii_radix_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .number     (number),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ascii_char (ascii_char),
        .is_last    (is_last)
    );

    // Shadow copy of the configuration registers. It is updated on each
    // config transfer.
    logic [RADIX_W-1:0] radix_now  = RADIX_RESET;
    logic               signed_now = 1'b0;

    // Characters still owed by the block, oldest first.
    char_exp_t char_q[$];

    stim_row_t dir_rows[$];
    // Typed string per directed row. Empty means the predictor is used.
    string     dir_text[$];

    // Idle bursts on both sides are enabled while this is set.
    bit gaps_on = 1'b1;

    int mismatches    = 0;
    int items_sent    = 0;
    int chars_checked = 0;
    int writes_done   = 0;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Radix as the block applies it: 0 and 1 saturate to 2, 17..31 to 16.
    function automatic logic [RADIX_W-1:0] active_base();
        if (radix_now < RADIX_MIN)
            return RADIX_MIN;
        if (radix_now > RADIX_MAX)
            return RADIX_MAX;
        return radix_now;
    endfunction

    // Predictor: repeated division by the base, then digits queued MSD first.
    function automatic void queue_digits(input logic [VALUE_WIDTH-1:0] val);
        logic [VALUE_WIDTH-1:0] mag;
        logic [VALUE_WIDTH-1:0] base;
        logic [DIGIT_W-1:0]     digs [MAX_DIGITS];
        logic [DIGIT_W-1:0]     d;
        int                     n;
        char_exp_t              e;
        base = VALUE_WIDTH'(active_base());
        mag  = val;
        // Two's complement magnitude. The most negative value maps onto
        // itself, which reads correctly as an unsigned magnitude.
        if (signed_now && mag[VALUE_WIDTH-1])
            mag = ~mag + 1'b1;
        n = 0;
        do
        begin
            digs[n] = DIGIT_W'(mag % base);
            mag     = mag / base;
            n++;
        end
        while (mag != 0 && n < MAX_DIGITS);
        for (int k = n - 1; k >= 0; k--)
        begin
            d      = digs[k];
            e.ch   = (d < 10) ? ASCII_ZERO + CHAR_W'(d) : ASCII_UPPER_A + CHAR_W'(d) - 7'd10;
            e.last = (k == 0);
            char_q.push_back(e);
        end
    endfunction

    function automatic void queue_text(input string s);
        char_exp_t e;
        byte       b;
        for (int i = 0; i < s.len(); i++)
        begin
            b      = s[i];
            e.ch   = b[CHAR_W-1:0];
            e.last = (i == s.len() - 1);
            char_q.push_back(e);
        end
    endfunction

    // Random number. The mix is full-width values, short values, small
    // negatives, radix power edges and the extremes.
    function automatic logic [VALUE_WIDTH-1:0] pick_value();
        logic [VALUE_WIDTH-1:0] v;
        logic [VALUE_WIDTH-1:0] p;
        logic [VALUE_WIDTH-1:0] base;
        int                     steps;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2: ;
            3, 4:    v = v >> $urandom_range(1, VALUE_WIDTH - 1);
            5:       v = VALUE_WIDTH'($urandom_range(0, 300));
            6:       v = ~VALUE_WIDTH'($urandom_range(0, 300)) + 1'b1;
            7:
            begin
                // base^k or base^k - 1. This is where the digit count changes.
                base  = VALUE_WIDTH'(active_base());
                p     = 1;
                steps = $urandom_range(1, MAX_DIGITS);
                for (int k = 0; k < steps && p <= ALL_ONES / base; k++)
                    p = p * base;
                v = p - VALUE_WIDTH'($urandom_range(0, 1));
                if (signed_now && $urandom_range(0, 1) == 1)
                    v = ~v + 1'b1;
            end
            8:       v = v | MOST_NEG;
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       v = '0;
                    1:       v = ALL_ONES;
                    2:       v = MOST_NEG;
                    default: v = ~MOST_NEG;
                endcase
            end
        endcase
        return v;
    endfunction

    // Block until every expected character is out, then let the block sit
    // quiet for the drain period set by DRAIN_CYCLES. Return on a falling edge, ready to drive.
    task automatic wait_drained();
        while (char_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // One number transfer. The expectation is queued at the accepting edge.
    task automatic send_number(input logic [VALUE_WIDTH-1:0] val, input string typed);
        if (gaps_on && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 11)) @(negedge clk);
        in_valid = 1'b1;
        number   = val;
        do
            @(posedge clk);
        while (in_stall);
        if (typed.len() == 0)
            queue_digits(val);
        else
            queue_text(typed);
        items_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Register writes happen only with the block idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RADIX_W-1:0] data);
        wait_drained();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_RADIX:  radix_now  = data;
            CFG_SIGNED: signed_now = data[0];
            default:    ;
        endcase
        writes_done++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic add_number(input logic [VALUE_WIDTH-1:0] val, input string typed);
        dir_rows.push_back('{ROW_NUMBER, CFG_RADIX, '0, val});
        dir_text.push_back(typed);
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [RADIX_W-1:0] data);
        dir_rows.push_back('{ROW_WRITE, idx, data, '0});
        dir_text.push_back("");
    endtask

    // Directed rows. They start from the reset config (base 10, unsigned).
    task automatic load_directed();
        add_number('0, "0");
        add_number(64'd1, "1");
        add_number(64'd10, "10");
        add_number(ALL_ONES, "18446744073709551615");
        add_number(MOST_NEG, "9223372036854775808");
        // signed: only the magnitude digits, no sign character
        add_write(CFG_SIGNED, 5'd1);
        add_number(ALL_ONES, "1");
        add_number(MOST_NEG, "9223372036854775808");
        add_number(~MOST_NEG, "9223372036854775807");
        add_number(MINUS_123, "123");
        add_write(CFG_RADIX, 5'd16);
        add_number(MOST_NEG, "8000000000000000");
        add_number(64'h0123_4567_89AB_CDEF, "123456789ABCDEF");
        // writes to unused indexes must not disturb radix or sign mode
        add_write(CFG_SPARE_2, 5'd3);
        add_write(CFG_SPARE_3, 5'd5);
        add_number(64'd255, "FF");
        add_write(CFG_SIGNED, 5'd0);
        // radix below two saturates to base 2
        add_write(CFG_RADIX, 5'd0);
        add_number(64'd5, "101");
        add_number(ALL_ONES, "");
        add_write(CFG_RADIX, 5'd1);
        add_number(64'd6, "110");
        // radix above sixteen saturates to base 16
        add_write(CFG_RADIX, 5'd31);
        add_number(ALL_ONES, "FFFFFFFFFFFFFFFF");
        add_write(CFG_RADIX, 5'd17);
        add_number(64'd171, "AB");
        add_write(CFG_RADIX, 5'd7);
        add_number(MOST_NEG, "");
        add_write(CFG_SIGNED, 5'd1);
        add_write(CFG_RADIX, 5'd2);
        add_number(MOST_NEG, "");
        add_number('0, "0");
    endtask

    // Output side: random stall bursts, driven on the
    // falling edge.
    initial
    begin
        int burst;
        burst     = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (burst > 0)
            begin
                burst--;
                out_stall = 1'b1;
            end
            else if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                burst     = $urandom_range(1, 11) - 1;
                out_stall = 1'b1;
            end
            else
                out_stall = 1'b0;
        end
    end

    // Scoreboard: each character transfer against the oldest expectation.
    char_exp_t want;
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (char_q.size() == 0)
            begin
                $display("%0t: unexpected char: expected none, got ascii_char=0x%02h is_last=%0b",
                         $time, ascii_char, is_last);
                mismatches++;
            end
            else
            begin
                want = char_q.pop_front();
                if (ascii_char !== want.ch)
                begin
                    $display("%0t: ascii_char mismatch: expected 0x%02h, got 0x%02h",
                             $time, want.ch, ascii_char);
                    mismatches++;
                end
                if (is_last !== want.last)
                begin
                    $display("%0t: is_last mismatch: expected %0b, got %0b",
                             $time, want.last, is_last);
                    mismatches++;
                end
                chars_checked++;
            end
        end
    end

    // Watchdog.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
        $display("tb_integer_to_ascii_radix_top: FAIL");
        $finish;
    end

    initial
    begin
        logic [RADIX_W-1:0] phase_radix;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        number    = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_RADIX;
        cfg_data  = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Directed rows, walked in order.
        load_directed();
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_WRITE)
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            else
                send_number(dir_rows[i].value, dir_text[i]);
        end

        // Random phases. Each phase uses its own radix and sign setting, and
        // each config change drains the block first. Phase 3 and the last
        // phase run without idle bursts.
        for (int p = 0; p < PHASES; p++)
        begin
            gaps_on = (p != 3) && (p != PHASES - 1);
            case (p)
                0:       phase_radix = 5'd2;
                1:       phase_radix = 5'd16;
                2:       phase_radix = 5'd10;
                3:       phase_radix = 5'd0;
                4:       phase_radix = 5'd31;
                5:       phase_radix = RADIX_W'($urandom_range(3, 15));
                6:       phase_radix = RADIX_W'($urandom_range(0, 31));
                default: phase_radix = RADIX_W'($urandom_range(2, 16));
            endcase
            write_reg(CFG_RADIX, phase_radix);
            // Upper data bits are noise. Only bit 0 sets the mode.
            write_reg(CFG_SIGNED, {RADIX_W'($urandom_range(0, 15)) << 1} | RADIX_W'(p % 2));
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                send_number(pick_value(), "");
                // Mid-phase: let the output side empty fully before going on.
                if (p == 2 && i == PHASE_ITEMS / 2)
                    wait_drained();
            end
        end

        gaps_on = 1'b0;
        wait_drained();
        $display("Converted %0d numbers (%0d chars checked) over %0d register writes,",
                 items_sent, chars_checked, writes_done);
        $display("bases 2..16 incl. saturated radix codes, signed and unsigned, with stalls.");
        if (mismatches == 0)
            $display("tb_integer_to_ascii_radix_top: PASS");
        else
            $display("tb_integer_to_ascii_radix_top: FAIL");
        $finish;
    end

endmodule

### integer_to_ascii_radix_top.f
hw/rtl/i2ar_pkg.sv
hw/rtl/i2ar_ram.sv
hw/rtl/i2ar_divider.sv
hw/rtl/integer_to_ascii_radix_top.sv
hw/rtl/i2ar_checker.sv
tb/tb_integer_to_ascii_radix_top.sv
